[rtl/core/lpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_pkg: shared types and constants of the LFO parameter animator
// Wave codes, register indexes, fixed-point widths and the control word of
// the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package lpa_pkg;

  // Default parameter values
  localparam int PHASE_BITS_DEF          = 24;
  localparam int SINE_TABLE_DEPTH_DEF    = 256;
  localparam int SIGMOID_TABLE_DEPTH_DEF = 256;

  // Q0.24 unit fraction, with room for exactly 1.0
  localparam int FRAC_BITS = 24;
  localparam int UNIT_BITS = FRAC_BITS + 1;

  // Shared MAC: 33-bit signed by 13-bit unsigned, 60-bit accumulator
  localparam int MAC_A_BITS = 33;
  localparam int MAC_B_BITS = 13;
  localparam int MAC_P_BITS = MAC_A_BITS + MAC_B_BITS + 1;
  localparam int ACC_BITS   = 60;

  typedef enum logic [2:0] {
    WAVE_STATIC   = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_SEESAW   = 3'd3,
    WAVE_TRIANGLE = 3'd4,
    WAVE_SAW      = 3'd5,
    WAVE_REV_SAW  = 3'd6,
    WAVE_NOISE    = 3'd7
  } wave_t;

  typedef enum logic [2:0] {
    REG_WAVE_TYPE     = 3'd0,
    REG_PHASE_STEP    = 3'd1,
    REG_MIN_VALUE     = 3'd2,
    REG_MAX_VALUE     = 3'd3,
    REG_SMOOTH_EN     = 3'd4,
    REG_SIDECHAIN_EN  = 3'd5,
    REG_NOISE_SEED    = 3'd6
  } reg_idx_t;

  // MAC control: en loads the accumulator, clear starts a new sum,
  // hi weights the product by 2^MAC_B_BITS
  typedef struct packed {
    logic en;
    logic clear;
    logic hi;
  } mac_ctl_t;

endpackage

[rtl/core/lpa_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_mac: shared multiply-accumulate unit
// One signed by unsigned product per cycle while en is set, added to a registered
// accumulator, optionally weighted by 2^MAC_B_BITS for the upper half.
// ----------------------------------------------------------------------------
module lpa_mac (
  input  logic                                 clk,
  input  lpa_pkg::mac_ctl_t                    ctl,
  input  logic signed [lpa_pkg::MAC_A_BITS-1:0] a,
  input  logic        [lpa_pkg::MAC_B_BITS-1:0] b,
  output logic signed [lpa_pkg::ACC_BITS-1:0]   acc
);
  import lpa_pkg::*;

  logic signed [MAC_P_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]   addend;
  logic signed [ACC_BITS-1:0]   base;

  // product, sign-extended and optionally weighted
  assign prod   = a * $signed({1'b0, b});
  assign addend = ctl.hi ?
      {{(ACC_BITS - MAC_P_BITS - MAC_B_BITS){prod[MAC_P_BITS-1]}}, prod, {MAC_B_BITS{1'b0}}} :
      {{(ACC_BITS - MAC_P_BITS){prod[MAC_P_BITS-1]}}, prod};
  assign base   = ctl.clear ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + addend;
    end
  end

endmodule

[rtl/core/lpa_shape.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpa_shape: waveform shaper
// Maps the Q0.24 phase (or the LFSR state) to a unit fraction for the
// selected wave. Sine and sigmoid tables are built at elaboration.
// ----------------------------------------------------------------------------
module lpa_shape #(
  parameter int SINE_TABLE_DEPTH    = lpa_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SIGMOID_TABLE_DEPTH = lpa_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
  input  lpa_pkg::wave_t                      wave_type,
  input  logic [lpa_pkg::FRAC_BITS-1:0]       phase,
  input  logic [31:0]                         lfsr,
  output logic [lpa_pkg::UNIT_BITS-1:0]       unit
);
  import lpa_pkg::*;

  localparam longint Q30         = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint UNIT24      = 64'sd16777216;

  localparam int SIG_ENTRIES   = SIGMOID_TABLE_DEPTH + 1;
  localparam int SIN_IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
  localparam int SIG_IDX_BITS  = $clog2(SIG_ENTRIES);
  localparam int SIN_PROD_BITS = FRAC_BITS + $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SIG_PROD_BITS = UNIT_BITS + $clog2(SIGMOID_TABLE_DEPTH + 1);

  // series term over one of the fixed small divisors, truncating toward zero
  function automatic longint series_div(input longint v, input int d);
    longint r;
    case (d)
      1:       r = v;
      2:       r = v / 64'sd2;
      3:       r = v / 64'sd3;
      4:       r = v / 64'sd4;
      5:       r = v / 64'sd5;
      6:       r = v / 64'sd6;
      7:       r = v / 64'sd7;
      8:       r = v / 64'sd8;
      9:       r = v / 64'sd9;
      10:      r = v / 64'sd10;
      11:      r = v / 64'sd11;
      12:      r = v / 64'sd12;
      20:      r = v / 64'sd20;
      42:      r = v / 64'sd42;
      72:      r = v / 64'sd72;
      110:     r = v / 64'sd110;
      156:     r = v / 64'sd156;
      default: r = 0;
    endcase
    return r;
  endfunction

  // Sine entry: Taylor series over a folded quarter wave, Q30, then Q0.24
  function automatic logic [UNIT_BITS-1:0] sine_entry(input int i);
    longint n, q, r, x, x2, term, s, v;
    n = 4 * longint'(i);
    q = n / SINE_TABLE_DEPTH;
    r = n % SINE_TABLE_DEPTH;
    if (q[0]) r = longint'(SINE_TABLE_DEPTH) - r;
    x = HALF_PI_Q30 * r / SINE_TABLE_DEPTH;
    x2 = (x * x) >>> 30;
    term = x;
    s = x;
    for (int k = 1; k <= 6; k++) begin
      term = series_div(-((term * x2) / Q30), (2 * k) * (2 * k + 1));
      s = s + term;
    end
    if (q >= 2) s = -s;
    v = Q30 / 2 + s / 2;
    if (v < 0) v = 0;
    if (v > Q30) v = Q30;
    v = (v + 32) >>> 6;
    if (v > UNIT24) v = UNIT24;
    return v[UNIT_BITS-1:0];
  endfunction

  // Sigmoid entry: exp(-y/16) by series, raised to the 16th by squaring
  function automatic logic [UNIT_BITS-1:0] sigmoid_entry(input int i);
    longint z, y, a, term, e, den, sp, num, quo, rem;
    z = 16 * longint'(i) - 8 * longint'(SIGMOID_TABLE_DEPTH);
    y = (z < 0 ? -z : z) * Q30 / SIGMOID_TABLE_DEPTH;
    a = y / 16;
    term = Q30;
    e = Q30;
    for (int k = 1; k <= 12; k++) begin
      term = series_div(-((term * a) / Q30), k);
      e = e + term;
    end
    if (e < 0) e = 0;
    for (int k = 0; k < 4; k++) begin
      e = e * e / Q30;
    end
    den = Q30 + e;
    num = 64'sd1 <<< 54;
    // restoring long division of 2^54 by den, rounded to nearest
    quo = 0;
    rem = 0;
    for (int b = 54; b >= 0; b--) begin
      rem = (rem <<< 1) + ((num >>> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo + (64'sd1 <<< b);
      end
    end
    sp = quo + ((rem * 2 >= den) ? 64'sd1 : 64'sd0);
    if (sp > UNIT24) sp = UNIT24;
    if (z < 0) sp = UNIT24 - sp;
    return sp[UNIT_BITS-1:0];
  endfunction

  logic [UNIT_BITS-1:0] sin_rom [SINE_TABLE_DEPTH];
  logic [UNIT_BITS-1:0] sig_rom [SIG_ENTRIES];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sin
    localparam logic [UNIT_BITS-1:0] SinVal = sine_entry(g);
    assign sin_rom[g] = SinVal;
  end

  for (genvar g = 0; g < SIG_ENTRIES; g++) begin : g_sig
    localparam logic [UNIT_BITS-1:0] SigVal = sigmoid_entry(g);
    assign sig_rom[g] = SigVal;
  end

  logic [UNIT_BITS:0]         tri_wide;
  logic [UNIT_BITS-1:0]       tri_val;
  logic [SIN_PROD_BITS-1:0]   sin_prod;
  logic [SIG_PROD_BITS-1:0]   sig_prod;
  logic [SIN_IDX_BITS-1:0]    sin_idx;
  logic [SIG_IDX_BITS-1:0]    sig_idx;
  logic [UNIT_BITS-1:0]       rev_val;

  // triangle: 2p below half a cycle, 2(1-p) above
  assign tri_wide = phase[FRAC_BITS-1] ?
                    (UNIT_BITS+1)'(1 << (FRAC_BITS + 1)) - (UNIT_BITS+1)'({phase, 1'b0}) :
                    (UNIT_BITS+1)'({phase, 1'b0});
  assign tri_val  = tri_wide[UNIT_BITS-1:0];
  assign rev_val  = UNIT_BITS'(1 << FRAC_BITS) - UNIT_BITS'(phase);

  // table indexes: floor(x * depth / 2^24)
  assign sin_prod = SIN_PROD_BITS'(phase) * SIN_PROD_BITS'(SINE_TABLE_DEPTH);
  assign sig_prod = SIG_PROD_BITS'(tri_val) * SIG_PROD_BITS'(SIGMOID_TABLE_DEPTH);
  assign sin_idx  = sin_prod[FRAC_BITS +: SIN_IDX_BITS];
  assign sig_idx  = sig_prod[FRAC_BITS +: SIG_IDX_BITS];

  always_comb begin
    unit = '0;
    unique case (wave_type)
      WAVE_SINE:     unit = sin_rom[sin_idx];
      WAVE_SEESAW:   unit = sig_rom[sig_idx];
      WAVE_TRIANGLE: unit = tri_val;
      WAVE_SAW:      unit = {1'b0, phase};
      WAVE_REV_SAW:  unit = rev_val;
      WAVE_NOISE:    unit = {1'b0, lfsr[31:8]};
      WAVE_STATIC,
      WAVE_SQUARE:   unit = '0;
      default:       unit = '0;
    endcase
  end

endmodule

[rtl/core/lfo_parameter_animator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_parameter_animator_top: LFO parameter animator
// Per sample tick, advances the phase, shapes it and scales it into the
// configured range, or follows the host or sidechain value with smoothing.
// ----------------------------------------------------------------------------
// Flow: one item at a time; in_ready only in idle, and finish waits for a
//   free output register. Per item the sequencer passes the shared
//   multiply-accumulate zero to three times (square none, direct static
//   none or one, scaled waves two, sidechain with smoothing three).
// Reset (synchronous): registers to defaults, phase and value to zero,
//   noise LFSR to 1, no item in flight.
// ----------------------------------------------------------------------------
module lfo_parameter_animator_top #(
  parameter int PHASE_BITS          = lpa_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH    = lpa_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SIGMOID_TABLE_DEPTH = lpa_pkg::SIGMOID_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        volume,
  input  logic signed [31:0] target_value,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] animated_value,
  output logic [23:0]        wave_phase
);
  import lpa_pkg::*;

  localparam int          EXT_BITS   = PHASE_BITS + FRAC_BITS;
  localparam int          UP_SHIFT   = (PHASE_BITS >= FRAC_BITS) ? PHASE_BITS - FRAC_BITS : 0;
  localparam int          DN_SHIFT   = (PHASE_BITS < FRAC_BITS) ? FRAC_BITS - PHASE_BITS : 0;
  localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
  localparam int          SUM_BITS   = 37;
  localparam logic [MAC_B_BITS-1:0] SMOOTH_NUM = MAC_B_BITS'(33);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHAPE,
    S_MUL_LO,
    S_MUL_HI,
    S_SCALE,
    S_SMOOTH_MUL,
    S_SMOOTH_ADD,
    S_FINISH
  } state_t;

  // saturate a wide signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [SUM_BITS-1:0] v);
    logic signed [31:0] r;
    if (v[SUM_BITS-1:31] == '0 || v[SUM_BITS-1:31] == '1) begin
      r = v[31:0];
    end else if (v[SUM_BITS-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  state_t                 state;
  // configuration registers
  wave_t                  wave_type;
  logic [23:0]            phase_step;
  logic signed [31:0]     min_value;
  logic signed [31:0]     max_value;
  logic                   smooth_enable;
  logic                   sidechain_enable;
  // state
  logic [PHASE_BITS-1:0]  phase_acc;
  logic signed [31:0]     current_value;
  logic [31:0]            noise_lfsr;
  // per-item working registers
  logic [15:0]            vol_q;
  logic signed [31:0]     target_q;
  logic [UNIT_BITS-1:0]   unit_q;
  logic signed [31:0]     val_q;

  logic [EXT_BITS-1:0]    step_ext;
  logic [EXT_BITS-1:0]    p_ext;
  logic [PHASE_BITS-1:0]  phase_inc;
  logic [23:0]            p24;
  logic [31:0]            lfsr_src;
  logic [31:0]            lfsr_next;
  logic [UNIT_BITS-1:0]   shape_unit;

  mac_ctl_t                     mac_ctl;
  logic signed [MAC_A_BITS-1:0] mac_a;
  logic [MAC_B_BITS-1:0]        mac_b;
  logic signed [ACC_BITS-1:0]   mac_acc;
  logic signed [MAC_A_BITS-1:0] range;
  logic signed [MAC_A_BITS-1:0] diff;
  logic signed [SUM_BITS-1:0]   scale_sum;
  logic signed [SUM_BITS-1:0]   smooth_sum;
  logic                         accept;
  logic                         out_free;

  // phase step and Q0.24 view of the accumulator
  assign step_ext  = (EXT_BITS'(phase_step) << UP_SHIFT) >> DN_SHIFT;
  assign phase_inc = step_ext[PHASE_BITS-1:0];
  assign p_ext     = (EXT_BITS'(phase_acc) >> UP_SHIFT) << DN_SHIFT;
  assign p24       = p_ext[23:0];

  // Galois LFSR step, zero state forced to 1
  assign lfsr_src  = (noise_lfsr == '0) ? 32'd1 : noise_lfsr;
  assign lfsr_next = lfsr_src[0] ? ({1'b0, lfsr_src[31:1]} ^ LFSR_TAPS) :
                                   {1'b0, lfsr_src[31:1]};

  lpa_shape #(
    .SINE_TABLE_DEPTH    (SINE_TABLE_DEPTH),
    .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
  ) u_shape (
    .wave_type (wave_type),
    .phase     (p24),
    .lfsr      (noise_lfsr),
    .unit      (shape_unit)
  );

  // operand selection for the shared MAC
  assign range = {max_value[31], max_value} - {min_value[31], min_value};
  assign diff  = {val_q[31], val_q} - {current_value[31], current_value};

  always_comb begin
    mac_ctl = '{en: 1'b0, clear: 1'b0, hi: 1'b0};
    mac_a   = range;
    mac_b   = unit_q[MAC_B_BITS-1:0];
    unique case (state)
      S_MUL_LO: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
      end
      S_MUL_HI: begin
        mac_ctl = '{en: 1'b1, clear: 1'b0, hi: 1'b1};
        mac_b   = MAC_B_BITS'(unit_q[UNIT_BITS-1:MAC_B_BITS]);
      end
      S_SMOOTH_MUL: begin
        mac_ctl = '{en: 1'b1, clear: 1'b1, hi: 1'b0};
        mac_a   = diff;
        mac_b   = SMOOTH_NUM;
      end
      default: begin
        mac_ctl = '{en: 1'b0, clear: 1'b0, hi: 1'b0};
      end
    endcase
  end

  lpa_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  // min + floor(range * u / 2^24), and cur + floor(diff * 33 / 2^16)
  assign scale_sum  = {{(SUM_BITS - 32){min_value[31]}}, min_value} +
                      SUM_BITS'({mac_acc[ACC_BITS-1], mac_acc[ACC_BITS-1:FRAC_BITS]});
  assign smooth_sum = {{(SUM_BITS - 32){current_value[31]}}, current_value} +
                      mac_acc[SUM_BITS+15:16];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // sequencer, configuration and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      wave_type        <= WAVE_STATIC;
      phase_step       <= '0;
      min_value        <= '0;
      max_value        <= 32'sd65536;
      smooth_enable    <= 1'b0;
      sidechain_enable <= 1'b0;
      phase_acc        <= '0;
      current_value    <= '0;
      noise_lfsr       <= 32'd1;
    end else begin
      // the finishing state reloads the output register itself
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_WAVE_TYPE:    wave_type        <= wave_t'(cfg_data[2:0]);
          REG_PHASE_STEP:   phase_step       <= cfg_data[23:0];
          REG_MIN_VALUE:    min_value        <= cfg_data;
          REG_MAX_VALUE:    max_value        <= cfg_data;
          REG_SMOOTH_EN:    smooth_enable    <= cfg_data[0];
          REG_SIDECHAIN_EN: sidechain_enable <= cfg_data[0];
          REG_NOISE_SEED:   noise_lfsr       <= (cfg_data == '0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            vol_q    <= volume;
            target_q <= target_value;
            if (wave_type != WAVE_STATIC) begin
              phase_acc <= phase_acc + phase_inc;
            end
            if (wave_type == WAVE_NOISE) begin
              noise_lfsr <= lfsr_next;
            end
            state <= S_SHAPE;
          end
        end
        S_SHAPE: begin
          unit_q <= (wave_type == WAVE_STATIC) ? {1'b0, vol_q, 8'd0} : shape_unit;
          if (wave_type == WAVE_SQUARE) begin
            val_q <= p24[23] ? min_value : max_value;
            state <= S_FINISH;
          end else if (wave_type == WAVE_STATIC && !sidechain_enable) begin
            val_q <= target_q;
            state <= smooth_enable ? S_SMOOTH_MUL : S_FINISH;
          end else begin
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          val_q <= sat32(scale_sum);
          if (wave_type == WAVE_STATIC && smooth_enable) begin
            state <= S_SMOOTH_MUL;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SMOOTH_MUL: begin
          state <= S_SMOOTH_ADD;
        end
        S_SMOOTH_ADD: begin
          val_q <= sat32(smooth_sum);
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hand the item to the output register once it is free
          if (out_free) begin
            animated_value <= val_q;
            wave_phase     <= p24;
            current_value  <= val_q;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
